/* hdl/pfs_pkg.sv */
// Shared constants, payload types and controller interface types of the paced fragment sender.
package pfs_pkg;

  // Capacity of the fragment map and the largest fragment in bytes.
  localparam int unsigned MaxFragments = 256;
  localparam int unsigned MaxFragBytes = 1024;

  // Field widths.
  localparam int unsigned BlockW   = 19;
  localparam int unsigned FragSzW  = 11;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned AckW     = 8;
  localparam int unsigned IdxOutW  = 8;
  localparam int unsigned OffW     = 18;
  localparam int unsigned ByteCntW = 11;
  localparam int unsigned AckCntW  = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Internal widths that follow from the map capacity.
  localparam int unsigned FragIdxW = $clog2(MaxFragments);
  localparam int unsigned FragCntW = $clog2(MaxFragments + 1);
  localparam int unsigned DivStepW = $clog2(FragCntW + 1);

  // The acknowledge map is scanned one segment per cycle.
  localparam int unsigned SegW     = (MaxFragments < 64) ? (1 << $clog2(MaxFragments)) : 64;
  localparam int unsigned NumSeg   = (MaxFragments + SegW - 1) / SegW;
  localparam int unsigned MapW     = NumSeg * SegW;
  localparam int unsigned MapIdxW  = $clog2(MapW);
  localparam int unsigned SegOffW  = $clog2(SegW);
  localparam int unsigned SegIdxW  = (NumSeg > 1) ? $clog2(NumSeg) : 1;
  localparam int unsigned PassW    = $clog2(NumSeg + 1);

  // Register values after reset.
  localparam int unsigned RstBlockSize    = 1024;
  localparam int unsigned RstFragSize     = 1024;
  localparam int unsigned RstSendInterval = 1000;
  localparam int unsigned RstFragCount    = (RstBlockSize + RstFragSize - 1) / RstFragSize;
  localparam int unsigned RstLastBytes    = RstBlockSize - (RstFragCount - 1) * RstFragSize;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 2'd0,
    OP_ACK     = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE    = 2'd0,
    CFG_FRAG_SIZE     = 2'd1,
    CFG_SEND_INTERVAL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [TimeW-1:0] current_time;
    logic [AckW-1:0]  ack_fragment;
  } item_t;

  typedef struct packed {
    logic                sent;
    logic [IdxOutW-1:0]  fragment_index;
    logic [OffW-1:0]     byte_offset;
    logic [ByteCntW-1:0] byte_count;
    logic [AckCntW-1:0]  acked_count;
    logic                all_acked;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic ack;
    logic clear;
    logic scan_init;
    logic scan_step;
    logic commit;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic           count_valid;
    logic [OpW-1:0] opcode;
    logic           tick_go;
    logic           found;
    logic           exhausted;
  } sts_t;

endpackage

/* hdl/pfs_frag_div.sv */
// Iterative divider that derives the fragment count and the last fragment's size.
module pfs_frag_div import pfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                kick_i,
  input  logic [BlockW-1:0]   block_size_i,
  input  logic [FragSzW-1:0]  frag_size_i,
  output logic                valid_o,
  output logic [FragCntW-1:0] frag_count_o,
  output logic [FragSzW-1:0]  last_bytes_o
);

  localparam int unsigned SatW = FragSzW + FragCntW;

  logic                pend_q;
  logic                run_q;
  logic                valid_q;
  logic [DivStepW-1:0] step_q;
  logic [FragSzW-1:0]  rem_q;
  logic [FragCntW-1:0] low_q;
  logic [FragCntW-1:0] quo_q;
  logic                sat_q;
  logic [FragCntW-1:0] cnt_q;
  logic [FragSzW-1:0]  last_q;

  logic [FragSzW:0]    trial;
  logic [FragSzW:0]    trial_sub;
  logic                fit;
  logic                sat_now;

  // One quotient bit per cycle: the quotient never needs more than FragCntW bits
  // once the saturating case is split off, so the top bits seed the remainder.
  assign trial     = {rem_q, low_q[FragCntW-1]};
  assign fit       = trial >= {1'b0, frag_size_i};
  assign trial_sub = trial - {1'b0, frag_size_i};
  assign sat_now   = SatW'(block_size_i) > (SatW'(frag_size_i) * SatW'(MaxFragments));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      run_q   <= 1'b0;
      valid_q <= 1'b1;
      step_q  <= '0;
      rem_q   <= '0;
      low_q   <= '0;
      quo_q   <= '0;
      sat_q   <= 1'b0;
      cnt_q   <= FragCntW'(RstFragCount);
      last_q  <= FragSzW'(RstLastBytes);
    end else if (kick_i) begin
      pend_q  <= 1'b1;
      run_q   <= 1'b0;
      valid_q <= 1'b0;
    end else if (pend_q) begin
      pend_q <= 1'b0;
      run_q  <= 1'b1;
      step_q <= DivStepW'(FragCntW);
      rem_q  <= FragSzW'(block_size_i >> FragCntW);
      low_q  <= block_size_i[FragCntW-1:0];
      quo_q  <= '0;
      sat_q  <= sat_now;
    end else if (run_q) begin
      if (step_q != '0) begin
        rem_q  <= fit ? FragSzW'(trial_sub) : FragSzW'(trial);
        quo_q  <= {quo_q[FragCntW-2:0], fit};
        low_q  <= low_q << 1;
        step_q <= step_q - DivStepW'(1);
      end else begin
        run_q   <= 1'b0;
        valid_q <= 1'b1;
        cnt_q   <= sat_q ? FragCntW'(MaxFragments) : quo_q + FragCntW'(rem_q != '0);
        last_q  <= (sat_q || rem_q == '0) ? frag_size_i : rem_q;
      end
    end
  end

  assign valid_o      = valid_q;
  assign frag_count_o = cnt_q;
  assign last_bytes_o = last_q;

endmodule

/* hdl/pfs_datapath.sv */
// Datapath: configuration registers, acknowledge map, segmented scan and result register.
module pfs_datapath import pfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  item_t               item_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                done_o,
  output result_t             result_o
);

  logic [BlockW-1:0]   block_size_q;
  logic [FragSzW-1:0]  frag_size_q;
  logic [TimeW-1:0]    send_interval_q;

  item_t               in_q;
  logic [MapW-1:0]     acked_q;
  logic [FragIdxW-1:0] cursor_q;
  logic [FragCntW-1:0] total_q;
  logic [TimeW-1:0]    last_send_q;

  logic [SegIdxW-1:0]  scan_seg_q;
  logic [PassW-1:0]    pass_q;
  logic [FragIdxW-1:0] start_q;
  logic [FragIdxW-1:0] found_idx_q;
  logic                sent_q;
  logic [OffW-1:0]     off_q;
  logic [ByteCntW-1:0] bytes_q;
  logic                done_q;
  result_t             res_q;

  logic                count_valid;
  logic [FragCntW-1:0] count;
  logic [FragSzW-1:0]  last_bytes;
  logic [FragSzW-1:0]  fs_eff;
  logic [TimeW-1:0]    elapsed;
  logic [MapIdxW-1:0]  ack_idx;
  logic                ack_new;
  logic [FragIdxW-1:0] cur_start;
  logic [SegW-1:0]     seg_bits;
  logic [SegW-1:0]     cand;
  logic [SegOffW-1:0]  found_off;
  logic                found;
  logic [SegIdxW-1:0]  seg_nxt;
  logic [FragIdxW+FragSzW-1:0] prod;
  logic [FragCntW-1:0] idx_inc;
  logic                is_last;

  pfs_frag_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kick_i       (cfg_we_i),
    .block_size_i (block_size_q),
    .frag_size_i  (fs_eff),
    .valid_o      (count_valid),
    .frag_count_o (count),
    .last_bytes_o (last_bytes)
  );

  // A fragment size of zero behaves as one byte; oversized values are clipped.
  always_comb begin
    if (frag_size_q == '0) begin
      fs_eff = FragSzW'(1);
    end else if (frag_size_q > FragSzW'(MaxFragBytes)) begin
      fs_eff = FragSzW'(MaxFragBytes);
    end else begin
      fs_eff = frag_size_q;
    end
  end

  assign elapsed   = in_q.current_time - last_send_q;
  assign ack_idx   = MapIdxW'(in_q.ack_fragment);
  assign ack_new   = ((AckW + FragCntW)'(in_q.ack_fragment) < (AckW + FragCntW)'(count)) &&
                     !acked_q[ack_idx];
  assign cur_start = (FragCntW'(cursor_q) < count) ? cursor_q : '0;

  // Candidates in the current segment: unacknowledged, in range, and on the
  // first visit not before the starting fragment.
  assign seg_bits = acked_q[scan_seg_q * SegW +: SegW];
  always_comb begin
    for (int j = 0; j < SegW; j++) begin
      cand[j] = !seg_bits[j] &&
                (FragCntW'({scan_seg_q, SegOffW'(j)}) < count) &&
                ((pass_q != '0) || (SegOffW'(j) >= start_q[SegOffW-1:0]));
    end
  end

  always_comb begin
    found_off = '0;
    for (int j = SegW - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found_off = SegOffW'(j);
      end
    end
  end

  assign found   = |cand;
  assign seg_nxt = (scan_seg_q == SegIdxW'(NumSeg - 1)) ? '0 : scan_seg_q + SegIdxW'(1);

  assign prod    = (FragIdxW + FragSzW)'(found_idx_q) * (FragIdxW + FragSzW)'(fs_eff);
  assign idx_inc = FragCntW'(found_idx_q) + FragCntW'(1);
  assign is_last = idx_inc == count;

  always_comb begin
    sts_o.count_valid = count_valid;
    sts_o.opcode      = in_q.opcode;
    sts_o.tick_go     = (elapsed > send_interval_q) && (count != '0);
    sts_o.found       = found;
    sts_o.exhausted   = !found && (pass_q == PassW'(NumSeg));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q    <= BlockW'(RstBlockSize);
      frag_size_q     <= FragSzW'(RstFragSize);
      send_interval_q <= TimeW'(RstSendInterval);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_SIZE:    block_size_q    <= cfg_wdata_i[BlockW-1:0];
        CFG_FRAG_SIZE:     frag_size_q     <= cfg_wdata_i[FragSzW-1:0];
        CFG_SEND_INTERVAL: send_interval_q <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q     <= '0;
      cursor_q    <= '0;
      total_q     <= '0;
      last_send_q <= '0;
      done_q      <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.clear) begin
        acked_q     <= '0;
        cursor_q    <= '0;
        total_q     <= '0;
        last_send_q <= '0;
      end else if (cmd_i.ack && ack_new) begin
        acked_q[ack_idx] <= 1'b1;
        total_q          <= total_q + FragCntW'(1);
      end else if (cmd_i.scan_step && sts_o.exhausted) begin
        cursor_q <= start_q;
      end else if (cmd_i.commit) begin
        cursor_q    <= (idx_inc < count) ? FragIdxW'(idx_inc) : '0;
        last_send_q <= in_q.current_time;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_q        <= item_i;
      sent_q      <= 1'b0;
      found_idx_q <= '0;
      off_q       <= '0;
      bytes_q     <= '0;
    end
    if (cmd_i.scan_init) begin
      start_q    <= cur_start;
      scan_seg_q <= SegIdxW'(cur_start >> SegOffW);
      pass_q     <= '0;
    end
    if (cmd_i.scan_step) begin
      if (found) begin
        found_idx_q <= FragIdxW'({scan_seg_q, found_off});
      end else begin
        scan_seg_q <= seg_nxt;
        pass_q     <= pass_q + PassW'(1);
      end
    end
    if (cmd_i.commit) begin
      sent_q  <= 1'b1;
      off_q   <= OffW'(prod);
      bytes_q <= is_last ? ByteCntW'(last_bytes) : ByteCntW'(fs_eff);
    end
    if (cmd_i.emit) begin
      res_q.sent           <= sent_q;
      res_q.fragment_index <= IdxOutW'(found_idx_q);
      res_q.byte_offset    <= off_q;
      res_q.byte_count     <= bytes_q;
      res_q.acked_count    <= AckCntW'(total_q);
      res_q.all_acked      <= total_q >= count;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_total_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(acked_q) == total_q)
    else $error("acknowledge count differs from the number of marked fragments");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_commit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (FragCntW'(found_idx_q) < count))
    else $error("sent fragment lies outside the block");

endmodule

/* hdl/pfs_ctrl.sv */
// Controller state machine that sequences decode, scan, send and result for each item.
module pfs_ctrl import pfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_DECODE,
    S_SCAN,
    S_COMMIT,
    S_RESULT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = sts_i.count_valid ? S_DECODE : S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.count_valid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESULT;
        case (sts_i.opcode)
          OP_RESTART: cmd_o.clear = 1'b1;
          OP_ACK:     cmd_o.ack = 1'b1;
          OP_TICK: begin
            if (sts_i.tick_go) begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.found) begin
          state_d = S_COMMIT;
        end else if (sts_i.exhausted) begin
          state_d = S_RESULT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= state_d != S_IDLE;
    end
  end

  assign busy = busy_q;

  a_busy_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != S_IDLE))
    else $error("busy flag out of step with the controller state");

  a_commit_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> ($past(state_q == S_SCAN) && $past(sts_i.found)))
    else $error("fragment sent without a scan hit");

  a_decode_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE) |-> sts_i.count_valid)
    else $error("item decoded before the fragment count was ready");

endmodule

/* hdl/paced_fragment_sender_core.sv */
// Top level of the paced fragment sender: controller and datapath.
//
// Usage. An item (tick, acknowledgement or restart) is transferred at a rising
// edge where start is high and busy is low. Every item yields exactly one
// result, shown on result_o for a single cycle with done_o high; the receiver
// cannot hold results off, and the block never waits for it.
// Configuration registers (block size, fragment size, send interval) are
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i while no item is in
// flight. Each write restarts an iterative divider that derives the fragment
// count and the size of the last fragment, one quotient bit per cycle; an item
// arriving before the divider finishes waits for it.
// Acknowledgements, restarts and ticks that are not yet due pass through the
// decode and result states, and the next item can be transferred in the cycle
// the result is shown. A due tick scans the acknowledge map one 64-bit segment
// per cycle and visits k segments (1 to 5); it then sends a fragment and shows
// its result, or shows a result with nothing sent when every fragment is
// already acknowledged.
// Reset clears all progress and loads the default register values (1024-byte
// block, 1024-byte fragments, interval 1000); no clearing pass is needed.
module paced_fragment_sender_core import pfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  item_t               item_i,
  output logic                busy,
  output logic                done_o,
  output result_t             result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Command and status bundles between controller and datapath.
  cmd_t cmd;
  sts_t sts;

  pfs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  pfs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

/* tb/pfs_send_checker.sv */
// Checker for the paced fragment sender: predicts every result and compares it with the block.
module pfs_send_checker import pfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  item_t               item_i,
  input  logic                done_i,
  input  result_t             result_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         error_count_o,
  output int unsigned         pending_o,
  output int unsigned         sends_o,
  output int unsigned         frag_count_o
);

  // Own copy of the registers and the sending progress.
  logic [BlockW-1:0]       block_size;
  logic [FragSzW-1:0]      frag_size;
  logic [TimeW-1:0]        send_interval;
  logic [MaxFragments-1:0] acked_map;
  int unsigned             send_cursor;
  int unsigned             acked_total;
  logic [TimeW-1:0]        last_send_time;
  int unsigned             eff_frag;

  result_t reports_due[$];
  result_t due_r;

  // Fragment size as used, and the fragment count that follows from the registers.
  always_comb begin
    if (frag_size == '0) begin
      eff_frag = 1;
    end else if (32'(frag_size) > MaxFragBytes) begin
      eff_frag = MaxFragBytes;
    end else begin
      eff_frag = 32'(frag_size);
    end
    frag_count_o = 32'(block_size) / eff_frag +
                   (((32'(block_size) % eff_frag) != 0) ? 1 : 0);
    if (frag_count_o > MaxFragments) begin
      frag_count_o = MaxFragments;
    end
  end

  // Applies one item to the progress state and returns the report it should produce.
  function automatic result_t predict_fragment_send(item_t it);
    result_t     r;
    int unsigned cur;
    int unsigned bytes;
    int unsigned base;
    int unsigned rest;
    int unsigned step;
    bit          found;
    r = '0;
    if (it.opcode == OP_RESTART) begin
      acked_map      = '0;
      send_cursor    = 0;
      acked_total    = 0;
      last_send_time = '0;
    end else if (it.opcode == OP_ACK) begin
      if (32'(it.ack_fragment) < frag_count_o && !acked_map[it.ack_fragment]) begin
        acked_map[it.ack_fragment] = 1'b1;
        acked_total++;
      end
    end else if (it.opcode == OP_TICK) begin
      if ((it.current_time - last_send_time) > send_interval && frag_count_o > 0) begin
        cur   = (send_cursor < frag_count_o) ? send_cursor : 0;
        found = 1'b0;
        for (step = 0; step < frag_count_o && !found; step++) begin
          if (!acked_map[FragIdxW'(cur)]) begin
            found = 1'b1;
          end else begin
            cur = (cur + 1 < frag_count_o) ? cur + 1 : 0;
          end
        end
        if (found) begin
          bytes = eff_frag;
          if (cur == frag_count_o - 1) begin
            base = (frag_count_o - 1) * eff_frag;
            rest = (32'(block_size) > base) ? 32'(block_size) - base : 0;
            if (rest < eff_frag) begin
              bytes = rest;
            end
          end
          r.sent           = 1'b1;
          r.fragment_index = IdxOutW'(cur);
          r.byte_offset    = OffW'(cur * eff_frag);
          r.byte_count     = ByteCntW'(bytes);
          last_send_time   = it.current_time;
          send_cursor      = (cur + 1 < frag_count_o) ? cur + 1 : 0;
        end else begin
          send_cursor = cur;
        end
      end
    end
    r.acked_count = AckCntW'(acked_total);
    r.all_acked   = (acked_total >= frag_count_o);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size     = BlockW'(RstBlockSize);
      frag_size      = FragSzW'(RstFragSize);
      send_interval  = TimeW'(RstSendInterval);
      acked_map      = '0;
      send_cursor    = 0;
      acked_total    = 0;
      last_send_time = '0;
      reports_due.delete();
      error_count_o  = 0;
      pending_o      = 0;
      sends_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_SIZE:    block_size = cfg_wdata_i[BlockW-1:0];
          CFG_FRAG_SIZE:     frag_size = cfg_wdata_i[FragSzW-1:0];
          CFG_SEND_INTERVAL: send_interval = cfg_wdata_i[TimeW-1:0];
          default: ;
        endcase
      end
      // The result of an earlier transfer is retired before a new one is predicted.
      if (done_i) begin
        if (result_i.sent === 1'b1) begin
          sends_o++;
        end
        if (reports_due.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10) begin
            $display("[%0t] result with no transfer awaiting it: sent=%0b idx=%0d", $time,
                     result_i.sent, result_i.fragment_index);
          end
        end else begin
          due_r = reports_due.pop_front();
          if (due_r.sent !== result_i.sent || due_r.fragment_index !== result_i.fragment_index ||
              due_r.byte_offset !== result_i.byte_offset ||
              due_r.byte_count !== result_i.byte_count ||
              due_r.acked_count !== result_i.acked_count ||
              due_r.all_acked !== result_i.all_acked) begin
            error_count_o++;
            if (error_count_o <= 10) begin
              $display("[%0t] mismatch: expected sent=%0b idx=%0d off=%0d cnt=%0d acked=%0d all=%0b",
                       $time, due_r.sent, due_r.fragment_index, due_r.byte_offset,
                       due_r.byte_count, due_r.acked_count, due_r.all_acked);
              $display("             got      sent=%0b idx=%0d off=%0d cnt=%0d acked=%0d all=%0b",
                       result_i.sent, result_i.fragment_index, result_i.byte_offset,
                       result_i.byte_count, result_i.acked_count, result_i.all_acked);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        reports_due.push_back(predict_fragment_send(item_i));
      end
      pending_o = reports_due.size();
    end
  end

endmodule

/* tb/tb_paced_fragment_sender_core.sv */
// Testbench top of the paced fragment sender: stimulus, idling phases and the final verdict.
module tb_paced_fragment_sender_core;
  import pfs_pkg::*;

  // The run is cut off here; a correct run needs a small fraction of this.
  localparam int unsigned CycleLimit   = 400000;
  // Cycles left to pass once nothing is outstanding: covers the longest scan
  // and the divider that a register write restarts.
  localparam int unsigned SettleCycles = 14;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhaseItems   = 105;
  // Opcode value the block has no meaning for; it must answer with status only.
  localparam logic [OpW-1:0] OpIgnored = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                done_o;
  item_t               item_i;
  result_t             result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int unsigned error_count;
  int unsigned pending;
  int unsigned sends;
  int unsigned frag_total;

  // Stimulus bookkeeping: the share of cycles the sender sits idle, the
  // running tick time and the interval last written.
  int unsigned      idle_pct;
  logic [TimeW-1:0] tick_time;
  int unsigned      pace;
  int unsigned      cycle_count;
  int unsigned      n_ticks;
  int unsigned      n_acks;
  int unsigned      n_restarts;
  int unsigned      n_ignored;
  int unsigned      n_settings;

  paced_fragment_sender_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .item_i      (item_i),
    .busy        (busy),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pfs_send_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .item_i        (item_i),
    .done_i        (done_o),
    .result_i      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .error_count_o (error_count),
    .pending_o     (pending),
    .sends_o       (sends),
    .frag_count_o  (frag_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Every task below is entered and left at a rising edge, so that each input
  // receives at most one nonblocking assignment in any time step.

  // Leaves start low for a random number of cycles, according to the phase.
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Offers one item and returns at the edge where its transfer takes place.
  // Start is left high, so a following item can go out back to back.
  task automatic issue(input logic [OpW-1:0] op, input logic [TimeW-1:0] now,
                       input logic [AckW-1:0] frag);
    sender_gap();
    start                <= 1'b1;
    item_i.opcode        <= op;
    item_i.current_time  <= now;
    item_i.ack_fragment  <= frag;
    do @(posedge clk_i); while (busy);
    case (op)
      OP_TICK:    n_ticks++;
      OP_ACK:     n_acks++;
      OP_RESTART: n_restarts++;
      default:    n_ignored++;
    endcase
  endtask

  // Holds the sender back until every predicted result has been seen, then lets
  // the block settle. The count is read at falling edges, away from the edge
  // where the checker updates it.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three registers while the block is idle. The checker picks the
  // writes up at the same edges as the block does.
  task automatic apply_setting(input logic [BlockW-1:0] block, input logic [FragSzW-1:0] frag,
                               input logic [TimeW-1:0] interval);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BLOCK_SIZE;
    cfg_wdata_i <= CfgDataW'(block);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FRAG_SIZE;
    cfg_wdata_i <= CfgDataW'(frag);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SEND_INTERVAL;
    cfg_wdata_i <= CfgDataW'(interval);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    pace = interval;
    n_settings++;
  endtask

  initial begin
    int unsigned      phase;
    int unsigned      item_no;
    int unsigned      sel;
    int unsigned      frag_bytes;
    logic [AckW-1:0]  frag_pick;

    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BLOCK_SIZE;
    cfg_wdata_i = '0;
    idle_pct    = 0;
    tick_time   = '0;
    pace        = RstSendInterval;
    n_ticks     = 0;
    n_acks      = 0;
    n_restarts  = 0;
    n_ignored   = 0;
    n_settings  = 1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. With the reset registers the block is one full fragment,
    // and a tick just past the default interval sends it.
    issue(OP_TICK, 32'd1001, 8'd0);

    // A 1000-byte block in 300-byte fragments: four fragments, the last one
    // carrying 100 bytes, paced at more than ten ticks.
    apply_setting(19'd1000, 11'd300, 32'd10);
    issue(OP_RESTART, 32'd0, 8'd0);
    issue(OP_TICK, 32'd5, 8'd0);
    // Exactly the interval has passed: pacing needs strictly more.
    issue(OP_TICK, 32'd10, 8'd0);
    issue(OP_TICK, 32'd11, 8'd0);
    issue(OP_TICK, 32'd22, 8'd0);
    // A repeated acknowledgement is not counted again; indexes at or above the
    // fragment count are dropped.
    issue(OP_ACK, 32'd0, 8'd1);
    issue(OP_ACK, 32'd0, 8'd1);
    issue(OP_ACK, 32'd0, 8'd4);
    issue(OP_ACK, 32'hFFFF_FFFF, 8'd255);
    // The scan goes on from the cursor to the short last fragment, then wraps back
    // to the start.
    issue(OP_TICK, 32'd40, 8'd0);
    issue(OP_TICK, 32'd60, 8'd0);
    issue(OP_TICK, 32'd80, 8'd0);
    issue(OP_ACK, 32'd0, 8'd0);
    issue(OP_ACK, 32'd0, 8'd2);
    issue(OP_ACK, 32'd0, 8'd3);
    // Everything is acknowledged: a due tick sends nothing.
    issue(OP_TICK, 32'd200, 8'd0);
    issue(OpIgnored, 32'hFFFF_FFFF, 8'hFF);
    issue(OP_RESTART, 32'hFFFF_FFFF, 8'hFF);
    // Elapsed time is taken modulo the time width, across the wrap of the clock.
    issue(OP_TICK, 32'hFFFF_FFFF, 8'd0);
    issue(OP_TICK, 32'h0000_0009, 8'd0);
    issue(OP_TICK, 32'h0000_000A, 8'd0);

    // Random part. The first phases hold the register extremes; the later ones
    // use random settings with few fragments, so that whole blocks get
    // acknowledged. State is carried over a setting change half of the time,
    // which leaves the cursor beyond a reduced fragment count.
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: apply_setting(19'd0, 11'd64, 32'd5);
        1: apply_setting(19'h7FFFF, 11'd0, 32'd3);
        2: apply_setting(19'h7FFFF, 11'h7FF, 32'd0);
        3: apply_setting(19'd1, 11'd1024, 32'd1);
        4: apply_setting(19'd262144, 11'd1024, 32'hFFFF_FFFF);
        default: begin
          frag_bytes = ($urandom_range(3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 600);
          if (frag_bytes == 0 || frag_bytes > MaxFragBytes) begin
            apply_setting(BlockW'($urandom_range(1, 8000)), FragSzW'(frag_bytes),
                          32'($urandom_range(0, 20)));
          end else begin
            apply_setting(BlockW'(frag_bytes * $urandom_range(1, 12) -
                                  $urandom_range(0, frag_bytes - 1)),
                          FragSzW'(frag_bytes), 32'($urandom_range(0, 20)));
          end
        end
      endcase
      // Sender idling: none, heavy and light, in turn.
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 84;
        default: idle_pct = 6;
      endcase
      if ($urandom_range(1) == 0) begin
        issue(OP_RESTART, $urandom, AckW'($urandom));
      end

      for (item_no = 0; item_no < PhaseItems; item_no++) begin
        sel = $urandom_range(99);
        if (sel < 48) begin
          // Ticks mostly advance by about the interval, so that sends fall
          // either side of the pacing boundary; some jump anywhere.
          if ($urandom_range(9) == 0 || pace >= 64) begin
            tick_time = $urandom;
          end else begin
            tick_time = tick_time + $urandom_range(0, pace + 2);
          end
          issue(OP_TICK, tick_time, AckW'($urandom));
        end else if (sel < 88) begin
          if (frag_total > 0 && $urandom_range(4) != 0) begin
            frag_pick = AckW'($urandom_range(0, frag_total - 1));
          end else begin
            frag_pick = AckW'($urandom_range(0, 255));
          end
          issue(OP_ACK, $urandom, frag_pick);
        end else if (sel < 93) begin
          issue(OP_RESTART, $urandom, AckW'($urandom));
        end else begin
          issue(OpIgnored, $urandom, AckW'($urandom));
        end
        // Now and then the sender waits for every outstanding result.
        if ($urandom_range(49) == 0) begin
          drain();
        end
      end
    end

    drain();
    $display("Covered %0d ticks, %0d acknowledgements, %0d restarts and %0d ignored items",
             n_ticks, n_acks, n_restarts, n_ignored);
    $display("over %0d register settings, with %0d fragments sent and %0d mismatches.",
             n_settings, sends, error_count);
    if (error_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
